// ===== rtl/rbsd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rbsd_pkg
// Shared sizes, command codes, status codes and register indexes of the
// ring buffer sync word deframer.
// ----------------------------------------------------------------------------
package rbsd_pkg;

    // ring geometry, depth is a power of two
    localparam int RING_DEPTH = 1024;
    localparam int AW         = $clog2(RING_DEPTH);
    localparam int CW         = AW + 1;

    // packet framing
    localparam int MAX_PACKET = 64;
    localparam int HDR_BYTES  = 8;
    localparam int LEN_HI_OFS = 6;
    localparam int LEN_LO_OFS = 7;
    localparam int SYNC_BYTES = 4;
    localparam int MIN_SEARCH = 5;
    localparam int IW         = $clog2(MAX_PACKET + 1);

    // commands
    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_ENQ = 2'd0;
    localparam t_cmd CMD_DEQ = 2'd1;
    localparam t_cmd CMD_CLR = 2'd2;

    // result status codes
    typedef logic [2:0] t_status;
    localparam t_status ST_OK         = 3'd0;
    localparam t_status ST_REJECT     = 3'd1;
    localparam t_status ST_FEW        = 3'd2;
    localparam t_status ST_INCOMPLETE = 3'd3;
    localparam t_status ST_QRESET     = 3'd4;
    localparam t_status ST_LONG       = 3'd5;

    // configuration register indexes
    localparam logic CFG_SYNC     = 1'b0;
    localparam logic CFG_MIN_FILL = 1'b1;

    localparam logic [31:0] SYNC_RESET     = 32'hD0F9EE5D;
    localparam logic [7:0]  MIN_FILL_RESET = 8'd10;

endpackage
`default_nettype wire

// ===== rtl/rbsd_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rbsd_store
// Byte ring storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rbsd_store
    import rbsd_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [7:0]    i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [7:0]    o_rdata
);

    logic [7:0] r_mem [RING_DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/ring_buffer_sync_word_deframer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ring_buffer_sync_word_deframer
// Byte ring buffer with a sync word / length field packet deframer.
// ----------------------------------------------------------------------------
// An enqueue, pointer reset or refused dequeue gives its single result in the
// next cycle; busy stays low so such commands may follow each other in every
// cycle. A dequeue streams the ring through the one read port of the byte
// store, whose read data is registered, one byte per cycle. Its passes are the
// sync search, the header and in-packet sync check, and the delivery pass,
// during which one byte beat per cycle leaves on o_strobe. A sync word found
// inside a packet restarts the search from it. Results cannot be held off by
// the receiver. The byte store is not cleared after reset.
// ----------------------------------------------------------------------------
module ring_buffer_sync_word_deframer
    import rbsd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [7:0]  i_data,
    input  wire logic        i_first,
    input  wire logic [10:0] i_burst_len,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    output logic             o_strobe,
    output logic [7:0]       o_byte_out,
    output logic             o_last,
    output logic [2:0]       o_status,
    output logic [6:0]       o_packet_len
);

    typedef enum logic [1:0] {S_IDLE, S_SRCH, S_VER, S_EMIT} t_state;

    t_state          r_state;
    logic [31:0]     r_sync;
    logic [7:0]      r_min_fill;
    logic [AW-1:0]   r_rp, r_wp, r_begin, r_scan, r_skip;
    logic [CW-1:0]   r_free;
    logic            r_acc;
    logic            r_q_vld;
    logic [31:0]     r_win;
    logic [2:0]      r_cnt;
    logic [IW-1:0]   r_i, r_cand;
    logic [2:0]      r_m;
    logic [7:0]      r_hi, r_lo;

    logic [7:0]      q;
    logic            accept;
    logic [AW-1:0]   avail;
    logic [31:0]     win_n;
    logic [2:0]      cnt_n;
    logic            hdr_long;
    logic [IW-1:0]   pkt_size;
    logic [7:0]      sync_sel;
    logic            few;
    logic            acc_n;
    logic            do_store;
    logic            i_ge_avail;

    // byte store
    rbsd_store u_store (
        .i_clk   (i_clk),
        .i_we    (do_store),
        .i_waddr (r_wp),
        .i_wdata (i_data),
        .i_raddr (r_scan),
        .o_rdata (q)
    );

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    // ring fill and search helpers
    assign avail      = r_wp - r_rp;
    assign win_n      = {r_win[23:0], q};
    assign cnt_n      = r_cnt + 3'd1;
    assign hdr_long   = (r_hi != 8'd0) || (r_lo > 8'(MAX_PACKET - HDR_BYTES));
    assign pkt_size   = r_lo[IW-1:0] + IW'(HDR_BYTES);
    assign i_ge_avail = 32'(r_i) >= 32'(avail);
    assign few        = (32'(r_free) + 32'(r_min_fill)) >= 32'(RING_DEPTH);

    // enqueue burst acceptance
    assign acc_n    = i_first ? ((i_burst_len > 11'd1) && (32'(r_free) > 32'(i_burst_len)))
                              : r_acc;
    assign do_store = accept && (i_cmd == CMD_ENQ) && acc_n && (r_free > CW'(1));

    // expected sync byte for the in-packet matcher
    always_comb begin
        case (r_m[1:0])
            2'd0:    sync_sel = r_sync[31:24];
            2'd1:    sync_sel = r_sync[23:16];
            2'd2:    sync_sel = r_sync[15:8];
            default: sync_sel = r_sync[7:0];
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync     <= SYNC_RESET;
            r_min_fill <= MIN_FILL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SYNC:     r_sync     <= i_cfg_data;
                CFG_MIN_FILL: r_min_fill <= i_cfg_data[7:0];
                default:      r_sync     <= r_sync;
            endcase
        end
    end

    // command sequencer, pointers and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rp     <= '0;
            r_wp     <= '0;
            r_free   <= CW'(RING_DEPTH);
            r_acc    <= 1'b0;
            r_q_vld  <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            o_strobe     <= 1'b0;
            o_byte_out   <= 8'd0;
            o_last       <= 1'b1;
            o_packet_len <= 7'd0;
            r_scan       <= r_scan + AW'(1);
            r_q_vld      <= (r_state != S_IDLE);
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (i_cmd)
                            CMD_ENQ: begin
                                r_acc    <= acc_n;
                                o_strobe <= 1'b1;
                                if (do_store) begin
                                    r_wp     <= r_wp + AW'(1);
                                    r_free   <= r_free - CW'(1);
                                    o_status <= ST_OK;
                                end else begin
                                    o_status <= ST_REJECT;
                                end
                            end
                            CMD_DEQ: begin
                                if (few) begin
                                    o_strobe <= 1'b1;
                                    o_status <= ST_FEW;
                                end else begin
                                    r_state <= S_SRCH;
                                    r_begin <= r_rp;
                                    r_skip  <= '0;
                                    r_scan  <= r_rp;
                                    r_cnt   <= 3'd0;
                                    r_q_vld <= 1'b0;
                                end
                            end
                            CMD_CLR: begin
                                r_rp     <= '0;
                                r_wp     <= '0;
                                r_free   <= CW'(RING_DEPTH);
                                o_strobe <= 1'b1;
                                o_status <= ST_OK;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                // sliding window search for the sync word
                S_SRCH: begin
                    if (r_q_vld) begin
                        if (cnt_n == 3'(SYNC_BYTES)) begin
                            if (32'(avail) < MIN_SEARCH) begin
                                r_rp     <= '0;
                                r_wp     <= '0;
                                r_free   <= CW'(RING_DEPTH);
                                o_strobe <= 1'b1;
                                o_status <= ST_QRESET;
                                r_state  <= S_IDLE;
                            end else if (win_n == r_sync) begin
                                if (32'(avail) < HDR_BYTES) begin
                                    r_rp     <= r_begin;
                                    o_strobe <= 1'b1;
                                    o_status <= ST_INCOMPLETE;
                                    r_state  <= S_IDLE;
                                end else begin
                                    r_state <= S_VER;
                                    r_scan  <= r_rp;
                                    r_q_vld <= 1'b0;
                                    r_i     <= '0;
                                    r_m     <= 3'd0;
                                end
                            end else begin
                                r_rp   <= r_rp + AW'(1);
                                r_skip <= r_skip + AW'(1);
                                r_win  <= win_n;
                                r_cnt  <= 3'(SYNC_BYTES - 1);
                            end
                        end else begin
                            r_win <= win_n;
                            r_cnt <= cnt_n;
                        end
                    end
                end
                // header read, length and in-packet sync check
                S_VER: begin
                    if (r_q_vld) begin
                        if (r_i >= IW'(HDR_BYTES) && hdr_long) begin
                            r_rp     <= r_rp + AW'(SYNC_BYTES);
                            r_free   <= r_free + CW'(r_skip) + CW'(SYNC_BYTES);
                            o_strobe <= 1'b1;
                            o_status <= ST_LONG;
                            r_state  <= S_IDLE;
                        end else if (r_i >= IW'(HDR_BYTES) && r_i == pkt_size) begin
                            r_state <= S_EMIT;
                            r_scan  <= r_rp;
                            r_q_vld <= 1'b0;
                            r_i     <= '0;
                        end else if (i_ge_avail) begin
                            r_rp     <= r_begin;
                            o_strobe <= 1'b1;
                            o_status <= ST_INCOMPLETE;
                            r_state  <= S_IDLE;
                        end else if (r_i >= IW'(SYNC_BYTES) && r_m == 3'(SYNC_BYTES)) begin
                            r_rp    <= r_rp + AW'(r_cand);
                            r_begin <= r_rp + AW'(r_cand);
                            r_scan  <= r_rp + AW'(r_cand);
                            r_free  <= r_free + CW'(r_skip) + CW'(r_cand);
                            r_skip  <= '0;
                            r_cnt   <= 3'd0;
                            r_q_vld <= 1'b0;
                            r_state <= S_SRCH;
                        end else begin
                            if (r_i == IW'(LEN_HI_OFS)) begin
                                r_hi <= q;
                            end
                            if (r_i == IW'(LEN_LO_OFS)) begin
                                r_lo <= q;
                            end
                            if (r_i >= IW'(SYNC_BYTES)) begin
                                if (r_m != 3'd0) begin
                                    r_m <= (q == sync_sel) ? r_m + 3'd1 : 3'd0;
                                end else if (q == sync_sel) begin
                                    r_m    <= 3'd1;
                                    r_cand <= r_i;
                                end
                            end
                            r_i <= r_i + IW'(1);
                        end
                    end
                end
                // deliver the packet, one byte beat per cycle
                S_EMIT: begin
                    if (r_q_vld) begin
                        o_strobe     <= 1'b1;
                        o_byte_out   <= q;
                        o_status     <= ST_OK;
                        o_packet_len <= 7'(pkt_size);
                        o_last       <= (r_i == pkt_size - IW'(1));
                        r_i          <= r_i + IW'(1);
                        if (r_i == pkt_size - IW'(1)) begin
                            r_rp    <= r_rp + AW'(pkt_size);
                            r_free  <= r_free + CW'(r_skip) + CW'(pkt_size);
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    // free space and stored bytes always add up to the ring depth when idle
    a_free_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (32'(r_free) + 32'(avail) == 32'(RING_DEPTH)))
        else $error("free count disagrees with pointers");

    // the ring never reports more free space than it has
    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_free) <= 32'(RING_DEPTH))
        else $error("free count above ring depth");

    // no byte is written while a dequeue walks the ring
    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !do_store)
        else $error("store write during dequeue");

    // a refused dequeue answers in the next cycle with too few bytes
    a_few_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd == CMD_DEQ && few) |=> (o_strobe && o_status == ST_FEW && !busy))
        else $error("refused dequeue not reported");
`endif

endmodule
`default_nettype wire
